// ===== rtl/slrg_pkg.sv =====
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared types, constants and helpers of the subtractive lagged generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slrg_pkg;

  localparam int unsigned WORD_W = 30;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned SEED_W = 28;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SEED_W-1:0] seed_t;

  localparam word_t MODULUS   = 30'd1000000000;
  localparam seed_t SEED_BASE = 28'd161803398;
  localparam idx_t  TBL_LAST  = 6'd54;
  localparam idx_t  STRIDE    = 6'd21;
  localparam idx_t  OFFSET    = 6'd30;
  localparam logic [IDX_W:0] TBL_LEN = 7'd55;

  // table port request from the sequencer
  typedef struct packed {
    logic  re;
    idx_t  rd_a_addr;
    idx_t  rd_b_addr;
    logic  we;
    idx_t  wr_addr;
    word_t wr_data;
  } mem_req_t;

  // (a - b) mod 10^9 for a, b below 10^9
  function automatic word_t sub_wrap(input word_t a, input word_t b);
    word_t diff;
    diff = a - b;
    if (a < b) begin
      diff = diff + MODULUS;
    end
    return diff;
  endfunction

  // ring increment over the table length
  function automatic idx_t idx_inc(input idx_t x);
    idx_t r;
    r = (x == TBL_LAST) ? '0 : x + 6'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/subtractive_lagged_random_generator.sv =====
// ----------------------------------------------------------------------------
// subtractive_lagged_random_generator
// Subtractive lagged generator modulo 10^9 over a 55-word lag table.
//
// Input channel (in_valid_i/in_ready_o) carries one draw_request_i word per
// handshake; a word with draw_request_i low is taken and gives no result.
// A draw gives one random_value_o word on the output channel
// (out_valid_o/out_ready_i), 0 to 999999999; the fraction is value / 10^9.
// Seed: cfg_we_i writes cfg_wdata_i into the seed register (reset value 1).
// The seed is used by the seeding that the first draw after reset runs:
// a fill write to every table entry and four mixing passes over the table,
// each entry read and then written, before that draw itself is done. Later
// draws are a table read, then subtract and write back, since the table
// memory has registered read ports; a new request is taken the cycle after
// a result is stored. A stalled receiver keeps the result in the output
// register; the next draw is accepted and read, then waits before its
// write-back until that register is free. Reset clears the control state
// and marks the table unseeded; the table contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module subtractive_lagged_random_generator import slrg_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire seed_t cfg_wdata_i,
  input  wire logic  in_valid_i,
  output      logic  in_ready_o,
  input  wire logic  draw_request_i,
  output      logic  out_valid_o,
  input  wire logic  out_ready_i,
  output      word_t random_value_o
);

  mem_req_t mem_req;
  word_t    rd_a_data;
  word_t    rd_b_data;

  slrg_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .draw_request_i (draw_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_value_o (random_value_o),
    .mem_req_o      (mem_req),
    .rd_a_data_i    (rd_a_data),
    .rd_b_data_i    (rd_b_data)
  );

  slrg_table u_table (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

endmodule

`default_nettype wire

// ===== rtl/slrg_table.sv =====
// ----------------------------------------------------------------------------
// slrg_table
// 55-word lag table: one write port, two synchronous read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_table import slrg_pkg::*; (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output      word_t    rd_a_data_o,
  output      word_t    rd_b_data_o
);

  word_t mem [55];
  word_t rd_a_q;
  word_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.re) begin
      rd_a_q <= mem[req_i.rd_a_addr];
      rd_b_q <= mem[req_i.rd_b_addr];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

`default_nettype wire

// ===== rtl/slrg_seq.sv =====
// ----------------------------------------------------------------------------
// slrg_seq
// Sequencer: seeding fill, mixing passes and draws over the lag table.
// ----------------------------------------------------------------------------
`default_nettype none

module slrg_seq import slrg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire seed_t    cfg_wdata_i,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire logic     draw_request_i,
  output      logic     out_valid_o,
  input  wire logic     out_ready_i,
  output      word_t    random_value_o,
  output      mem_req_t mem_req_o,
  input  wire word_t    rd_a_data_i,
  input  wire word_t    rd_b_data_i
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FILL    = 3'd1;
  localparam logic [2:0] ST_MIX_RD  = 3'd2;
  localparam logic [2:0] ST_MIX_WR  = 3'd3;
  localparam logic [2:0] ST_DRAW_RD = 3'd4;
  localparam logic [2:0] ST_DRAW_WR = 3'd5;

  logic [2:0] state_q, state_d;
  logic       seeded_q, seeded_d;
  idx_t       rd_idx_q, rd_idx_d;
  idx_t       lag_idx_q, lag_idx_d;
  idx_t       cnt_q, cnt_d;
  idx_t       part_q, part_d;
  idx_t       pos_q, pos_d;
  logic [1:0] pass_q, pass_d;
  word_t      cur_q, cur_d;
  word_t      prev_q, prev_d;
  seed_t      seed_q;
  logic       out_valid_q, out_valid_d;
  word_t      out_data_q, out_data_d;

  seed_t          seed_sat;
  word_t          cur_init;
  logic [IDX_W:0] pos_sum;
  idx_t           pos_nx;
  idx_t           rd_nx;
  idx_t           lag_nx;
  word_t          diff;
  logic           in_acc;

  assign seed_sat = (seed_q > SEED_BASE) ? SEED_BASE : seed_q;
  assign cur_init = {2'b00, SEED_BASE - seed_sat};
  assign pos_sum  = {1'b0, pos_q} + {1'b0, STRIDE};
  assign pos_nx   = (pos_sum >= TBL_LEN) ? IDX_W'(pos_sum - TBL_LEN) : pos_sum[IDX_W-1:0];
  assign rd_nx    = idx_inc(rd_idx_q);
  assign lag_nx   = idx_inc(lag_idx_q);
  assign diff     = sub_wrap(rd_a_data_i, rd_b_data_i);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    rd_idx_d    = rd_idx_q;
    lag_idx_d   = lag_idx_q;
    cnt_d       = cnt_q;
    part_d      = part_q;
    pos_d       = pos_q;
    pass_d      = pass_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    mem_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && draw_request_i) begin
          if (seeded_q) begin
            mem_req_o.re        = 1'b1;
            mem_req_o.rd_a_addr = rd_nx;
            mem_req_o.rd_b_addr = lag_nx;
            rd_idx_d            = rd_nx;
            lag_idx_d           = lag_nx;
            state_d             = ST_DRAW_WR;
          end else begin
            mem_req_o.we      = 1'b1;
            mem_req_o.wr_addr = TBL_LAST;
            mem_req_o.wr_data = cur_init;
            cur_d             = cur_init;
            prev_d            = 30'd1;
            pos_d             = STRIDE;
            cnt_d             = '0;
            state_d           = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        mem_req_o.we      = 1'b1;
        mem_req_o.wr_addr = pos_q;
        mem_req_o.wr_data = prev_q;
        prev_d            = sub_wrap(cur_q, prev_q);
        cur_d             = prev_q;
        pos_d             = pos_nx;
        cnt_d             = cnt_q + 6'd1;
        if (cnt_q == TBL_LAST) begin
          cnt_d   = '0;
          part_d  = OFFSET;
          pass_d  = '0;
          state_d = ST_MIX_RD;
        end
      end
      ST_MIX_RD: begin
        mem_req_o.re        = 1'b1;
        mem_req_o.rd_a_addr = cnt_q;
        mem_req_o.rd_b_addr = part_q;
        state_d             = ST_MIX_WR;
      end
      ST_MIX_WR: begin
        mem_req_o.we      = 1'b1;
        mem_req_o.wr_addr = cnt_q;
        mem_req_o.wr_data = diff;
        cnt_d             = idx_inc(cnt_q);
        part_d            = idx_inc(part_q);
        state_d           = ST_MIX_RD;
        if (cnt_q == TBL_LAST) begin
          pass_d = pass_q + 2'd1;
          if (pass_q == 2'd3) begin
            seeded_d  = 1'b1;
            rd_idx_d  = TBL_LAST;
            lag_idx_d = OFFSET;
            state_d   = ST_DRAW_RD;
          end
        end
      end
      ST_DRAW_RD: begin
        mem_req_o.re        = 1'b1;
        mem_req_o.rd_a_addr = rd_nx;
        mem_req_o.rd_b_addr = lag_nx;
        rd_idx_d            = rd_nx;
        lag_idx_d           = lag_nx;
        state_d             = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        if (!out_valid_q || out_ready_i) begin
          mem_req_o.we      = 1'b1;
          mem_req_o.wr_addr = rd_idx_q;
          mem_req_o.wr_data = diff;
          out_valid_d       = 1'b1;
          out_data_d        = diff;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seeded_q    <= 1'b0;
      rd_idx_q    <= '0;
      lag_idx_q   <= '0;
      cnt_q       <= '0;
      part_q      <= '0;
      pos_q       <= '0;
      pass_q      <= '0;
      seed_q      <= 28'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      rd_idx_q    <= rd_idx_d;
      lag_idx_q   <= lag_idx_d;
      cnt_q       <= cnt_d;
      part_q      <= part_d;
      pos_q       <= pos_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

endmodule

`default_nettype wire
